// ----- src/lem_pkg.sv -----
// shared types and constants for the label edge marker
`default_nettype none

package lem_pkg;

    // default sizes of the frame store
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_LABEL_BITS = 8;

    // fixed field widths of the ports
    localparam int COORD_BITS     = 8;
    localparam int LABEL_FIELD    = 8;
    localparam int SIZE_BITS      = 9;
    localparam int CFG_INDEX_BITS = 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TARGET_LABEL = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_EDGE_LABEL   = 2'd3;

    // register reset values
    localparam logic [SIZE_BITS-1:0]   RST_IMAGE_WIDTH  = 9'd256;
    localparam logic [SIZE_BITS-1:0]   RST_IMAGE_HEIGHT = 9'd256;
    localparam logic [LABEL_FIELD-1:0] RST_TARGET_LABEL = 8'd0;
    localparam logic [LABEL_FIELD-1:0] RST_EDGE_LABEL   = 8'd1;

    // item actions
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // sequencer states: one memory read issued per neighbour state
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEFT,
        ST_RIGHT,
        ST_UP,
        ST_DOWN,
        ST_FINISH
    } lem_state_t;

endpackage

`default_nettype wire

// ----- src/lem_ram.sv -----
// generic single-port ram with registered read
`default_nettype none

module lem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write or registered read, read data holds when idle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/label_edge_marker.sv -----
// top level of the label edge marker: frame store and read sequencer
//
//  channel | direction | handshake          | word
//  in      | input     | in_valid/in_stall  | action, column, row, label_in
//  out     | output    | out_valid/out_stall| label_out, out_of_range
//  cfg     | input     | cfg_write          | cfg_index, cfg_data
//
// a load or out-of-range word goes from idle to the finish state, then to the output
// register once free; the input is stalled until the sequencer is back in idle.
// a read word runs the left, right, up, down and finish states with the input stalled:
// centre, left, right, up and down are fetched one after another through the single port
// of the frame ram, then the result is registered.
// the next word is taken when the sequencer is back in idle, even while a result waits.
// no clearing pass after reset: the frame ram holds garbage until loaded.
// a stalled output holds its word; the sequencer waits in its finish state.
`default_nettype none

module label_edge_marker
    import lem_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int LABEL_BITS = DEF_LABEL_BITS
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // input channel
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic                      action,
    input  wire logic [COORD_BITS-1:0]     column,
    input  wire logic [COORD_BITS-1:0]     row,
    input  wire logic [LABEL_FIELD-1:0]    label_in,
    // output channel
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic      [LABEL_FIELD-1:0]    label_out,
    output logic                           out_of_range,
    // configuration port
    input  wire logic                      cfg_write,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [SIZE_BITS-1:0]      cfg_data
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int AW    = CW + RW;
    localparam int DEPTH = 1 << AW;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);

    // configuration registers
    logic [SIZE_BITS-1:0]   image_width_reg;
    logic [SIZE_BITS-1:0]   image_height_reg;
    logic [LABEL_FIELD-1:0] target_label_reg;
    logic [LABEL_FIELD-1:0] edge_label_reg;

    // sequencer state
    lem_state_t      state_reg;
    lem_state_t      state_next;
    logic [CW-1:0]   col_reg;
    logic [RW-1:0]   row_reg;
    logic            is_read_reg;
    logic            oor_reg;
    logic            has_left_reg;
    logic            has_right_reg;
    logic            has_up_reg;
    logic            has_down_reg;
    logic [LABEL_BITS-1:0] centre_reg;
    logic            touch_reg;

    // output register
    logic                   out_valid_reg;
    logic [LABEL_FIELD-1:0] label_out_reg;
    logic                   out_of_range_reg;

    // ram port
    logic                  ram_en;
    logic                  ram_we;
    logic [AW-1:0]         ram_addr;
    logic [LABEL_BITS-1:0] ram_rdata;

    logic [WW-1:0]         used_w;
    logic [HW-1:0]         used_h;
    logic                  in_range;
    logic                  accept;
    logic [CW-1:0]         col_in;
    logic [RW-1:0]         row_in;
    logic [LABEL_BITS-1:0] tgt;
    logic [LABEL_BITS-1:0] edg;
    logic                  rd_hit;
    logic                  out_free;
    logic                  touch_final;
    logic [LABEL_BITS-1:0] result;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
            target_label_reg <= RST_TARGET_LABEL;
            edge_label_reg   <= RST_EDGE_LABEL;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                CFG_TARGET_LABEL: target_label_reg <= cfg_data[LABEL_FIELD-1:0];
                CFG_EDGE_LABEL:   edge_label_reg   <= cfg_data[LABEL_FIELD-1:0];
                default: ;
            endcase
        end
    end

    // size in use, saturated to the frame store
    assign used_w = (32'(image_width_reg) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(image_width_reg);
    assign used_h = (32'(image_height_reg) > MAX_HEIGHT) ? HW'(MAX_HEIGHT)
                                                         : HW'(image_height_reg);

    assign in_range = (32'(column) < 32'(used_w)) && (32'(row) < 32'(used_h));
    assign col_in   = CW'(column);
    assign row_in   = RW'(row);
    assign tgt      = LABEL_BITS'(target_label_reg);
    assign edg      = LABEL_BITS'(edge_label_reg);

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign rd_hit   = (ram_rdata == tgt);
    assign out_free = !out_valid_reg || !out_stall;

    // final neighbour check and result select
    assign touch_final = touch_reg || (has_down_reg && rd_hit);
    assign result = !is_read_reg ? '0 :
                    ((centre_reg != tgt) && touch_final) ? edg : centre_reg;

    // next state and ram access
    always_comb
    begin
        state_next = state_reg;
        ram_en     = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = {row_reg, col_reg};
        case (state_reg)
            ST_IDLE:
            begin
                ram_addr = {row_in, col_in};
                if (accept)
                begin
                    ram_en = in_range;
                    ram_we = (action == ACT_LOAD);
                    state_next = (in_range && action == ACT_READ) ? ST_LEFT : ST_FINISH;
                end
            end
            ST_LEFT:
            begin
                ram_en     = 1'b1;
                ram_addr   = {row_reg, col_reg - CW'(1)};
                state_next = ST_RIGHT;
            end
            ST_RIGHT:
            begin
                ram_en     = 1'b1;
                ram_addr   = {row_reg, col_reg + CW'(1)};
                state_next = ST_UP;
            end
            ST_UP:
            begin
                ram_en     = 1'b1;
                ram_addr   = {row_reg - RW'(1), col_reg};
                state_next = ST_DOWN;
            end
            ST_DOWN:
            begin
                ram_en     = 1'b1;
                ram_addr   = {row_reg + RW'(1), col_reg};
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // word capture and neighbour accumulation
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_reg       <= col_in;
            row_reg       <= row_in;
            is_read_reg   <= (action == ACT_READ) && in_range;
            oor_reg       <= !in_range;
            has_left_reg  <= (column != '0);
            has_right_reg <= (32'(column) + 1 < 32'(used_w));
            has_up_reg    <= (row != '0);
            has_down_reg  <= (32'(row) + 1 < 32'(used_h));
        end
        case (state_reg)
            ST_LEFT:
            begin
                centre_reg <= ram_rdata;
                touch_reg  <= 1'b0;
            end
            ST_RIGHT: touch_reg <= touch_reg || (has_left_reg && rd_hit);
            ST_UP:    touch_reg <= touch_reg || (has_right_reg && rd_hit);
            ST_DOWN:  touch_reg <= touch_reg || (has_up_reg && rd_hit);
            default: ;
        endcase
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_FINISH && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FINISH && out_free)
        begin
            label_out_reg    <= LABEL_FIELD'(result);
            out_of_range_reg <= oor_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign label_out    = label_out_reg;
    assign out_of_range = out_of_range_reg;

    // frame store
    lem_ram #(
        .WIDTH(LABEL_BITS),
        .DEPTH(DEPTH)
    ) u_frame (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (LABEL_BITS'(label_in)),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

// ----- src/lem_checker.sv -----
// port checker for the label edge marker and its bind
`default_nettype none

module lem_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] label_out,
    input wire logic       out_of_range
);

    // a stalled output word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(label_out) && $stable(out_of_range))
    else $error("stalled output word changed");

    // an out-of-range word carries a zero label
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> label_out == 8'd0)
    else $error("out-of-range word with nonzero label");

    // one word at a time: busy right after acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

    // no output word while in reset
    assert property (@(posedge clk) !rst_n |-> !out_valid)
    else $error("output valid during reset");

endmodule

bind label_edge_marker lem_checker u_lem_checker (.*);

`default_nettype wire
